// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mcac_pkg.sv =====
// Types, constants and helpers shared by the cross-axis correction block.
package mcac_pkg;
	localparam int INV_FRAC_BITS = 16;
	localparam int RAW_W = 16;
	localparam int INV_W = 24;
	localparam int LC_W = 32;
	localparam int OUT_W = 24;
	localparam int ROW_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int ADJ_W = 33;
	localparam int ADJ_MAG_W = 32;
	localparam int DET_W = 51;
	localparam int DEN_W = 50;
	localparam int SCALE_W = 9;
	localparam int DVD_W = ADJ_MAG_W + SCALE_W + INV_FRAC_BITS + 2;
	localparam int DVS_W = DEN_W + 1;
	localparam int PROD_W = RAW_W + INV_W;
	localparam int ACC_W = PROD_W + 2;
	localparam int RND_SH = INV_FRAC_BITS - 8;

	localparam logic [SCALE_W-1:0] CAL_SCALE = SCALE_W'(330);
	localparam logic signed [RAW_W-1:0] NO_FACTORY = -16'sd1;
	localparam logic [1:0] AXIS_LAST = 2'd2;
	localparam logic [DVD_W-1:0] Q_POS_LIM = DVD_W'((64'd1 << (INV_W - 1)) - 64'd1);
	localparam logic [DVD_W-1:0] Q_NEG_LIM = DVD_W'(64'd1 << (INV_W - 1));
	localparam logic signed [INV_W-1:0] INV_ONE = INV_W'(64'd1 << INV_FRAC_BITS);

	typedef enum logic [1:0] {
		ST_FRESH    = 2'd0,
		ST_STALE    = 2'd1,
		ST_FACTORY  = 2'd2,
		ST_IDENTITY = 2'd3
	} res_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_X = 3'd0,
		CFG_ROW_Y = 3'd1,
		CFG_ROW_Z = 3'd2,
		CFG_SRC_X = 3'd3,
		CFG_SRC_Y = 3'd4,
		CFG_SRC_Z = 3'd5,
		CFG_SIGN  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0][ROW_W-1:0] rows;
		logic [2:0][1:0]       src;
		logic [2:0]            sign;
	} cfg_t;

	typedef struct packed {
		logic        capture;
		logic        mac_clr;
		logic        mac_en;
		logic        rnd_en;
		logic        adj_en;
		logic        det_clr;
		logic        det_en;
		logic        div_start;
		logic        inv_wr;
		logic        ident_load;
		logic        out_load;
		logic [1:0]  row;
		logic [1:0]  col;
		res_status_t status;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic data_ready;
		logic no_factory;
		logic det_zero;
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic [3:0] d;
	} cof_sel_t;

	// Cofactor (r,c) of the adjugate is w[a]*w[b] - w[c]*w[d], words flattened row-major.
	function automatic cof_sel_t cof_sel(input logic [1:0] r, input logic [1:0] c);
		cof_sel_t s;
		case ({r, c})
			4'h0: s = '{4'd4, 4'd8, 4'd5, 4'd7};
			4'h1: s = '{4'd2, 4'd7, 4'd1, 4'd8};
			4'h2: s = '{4'd1, 4'd5, 4'd2, 4'd4};
			4'h4: s = '{4'd5, 4'd6, 4'd3, 4'd8};
			4'h5: s = '{4'd0, 4'd8, 4'd2, 4'd6};
			4'h6: s = '{4'd2, 4'd3, 4'd0, 4'd5};
			4'h8: s = '{4'd3, 4'd7, 4'd4, 4'd6};
			4'h9: s = '{4'd1, 4'd6, 4'd0, 4'd7};
			4'hA: s = '{4'd0, 4'd4, 4'd1, 4'd3};
			default: s = '{4'd0, 4'd0, 4'd0, 4'd0};
		endcase
		return s;
	endfunction
endpackage

// ===== design/mcac_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mcac_div
	import mcac_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== design/mcac_dp.sv =====
// Datapath: adjugate, determinant, inverse store, sample MAC and output scaling.
module mcac_dp
	import mcac_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  cfg_t                    cfg,
	input  logic                    op,
	input  logic                    data_ready,
	input  logic signed [RAW_W-1:0] raw_x,
	input  logic signed [RAW_W-1:0] raw_y,
	input  logic signed [RAW_W-1:0] raw_z,
	output sts_t                    sts,
	output logic signed [OUT_W-1:0] field_x,
	output logic signed [OUT_W-1:0] field_y,
	output logic signed [OUT_W-1:0] field_z,
	output logic [1:0]              status
);
	localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'((64'd1 << RND_SH) >> 1);
	localparam logic [ACC_W-1:0] LC_POS = ACC_W'((64'd1 << (LC_W - 1)) - 64'd1);
	localparam logic [ACC_W-1:0] LC_NEG = ACC_W'(64'd1 << (LC_W - 1));
	localparam int T_W = LC_W + 2;
	localparam logic [T_W-1:0] T_POS = T_W'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [T_W-1:0] T_NEG = T_W'(64'd1 << (OUT_W - 1));

	logic                      op_q;
	logic                      dr_q;
	logic signed [RAW_W-1:0]   raw_q [3];
	logic signed [RAW_W-1:0]   w [9];
	logic signed [ADJ_W-1:0]   adj_q [3][3];
	logic signed [DET_W-1:0]   det_q;
	logic signed [INV_W-1:0]   inv_q [3][3];
	logic signed [ACC_W-1:0]   acc_q [3];
	logic signed [LC_W-1:0]    lc_q [3];
	logic                      neg_q;
	logic signed [OUT_W-1:0]   fx_q, fy_q, fz_q;
	logic [1:0]                status_q;

	cof_sel_t                     sel;
	logic signed [2*RAW_W-1:0]    pa, pb;
	logic signed [ADJ_W-1:0]      cof;
	logic signed [RAW_W+ADJ_W-1:0] pd;
	logic signed [ADJ_W-1:0]      cval;
	logic [ADJ_MAG_W-1:0]         cmag;
	logic [ADJ_MAG_W+SCALE_W-1:0] cscaled;
	logic [DEN_W-1:0]             dmag;
	logic [DVD_W-1:0]             dividend;
	logic [DVS_W-1:0]             divisor;
	logic                         div_done;
	logic [DVD_W-1:0]             quo;
	logic signed [INV_W-1:0]      inv_val;
	logic signed [RAW_W-1:0]      raw_sel;
	logic signed [PROD_W-1:0]     prod [3];

	function automatic logic signed [LC_W-1:0] acc_to_lc(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] m;
		mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
		m = (mag + ACC_HALF) >> RND_SH;
		if (a[ACC_W-1])
			return (m > LC_NEG) ? LC_W'(LC_NEG) : LC_W'(-m);
		return (m > LC_POS) ? LC_W'(LC_POS) : LC_W'(m);
	endfunction

	function automatic logic signed [OUT_W-1:0] out_axis(
		input logic [1:0] src, input logic negate,
		input logic signed [LC_W-1:0] l0, input logic signed [LC_W-1:0] l1,
		input logic signed [LC_W-1:0] l2
	);
		logic signed [LC_W-1:0] v;
		logic signed [T_W-1:0]  t;
		logic [T_W-1:0]         mag;
		logic [T_W-1:0]         m;
		logic                   s;
		case (src)
			2'd0: v = l0;
			2'd1: v = l1;
			2'd2: v = l2;
			default: v = '0;
		endcase
		t = T_W'(v) + (T_W'(v) <<< 1);
		mag = t[T_W-1] ? T_W'(-t) : T_W'(t);
		m = (mag + T_W'(128)) >> 8;
		s = t[T_W-1] ^ negate;
		if (s)
			return (m > T_NEG) ? OUT_W'(T_NEG) : OUT_W'(-m);
		return (m > T_POS) ? OUT_W'(T_POS) : OUT_W'(m);
	endfunction

	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				w[r*3+c] = cfg.rows[r][c*RAW_W +: RAW_W];
	end

	// Cofactor and determinant terms
	assign sel = cof_sel(cmd.row, cmd.col);
	assign pa  = w[sel.a] * w[sel.b];
	assign pb  = w[sel.c] * w[sel.d];
	assign cof = ADJ_W'(pa) - ADJ_W'(pb);
	assign pd  = w[{2'b00, cmd.row}] * adj_q[cmd.row][0];

	// Divider operands: |c| * 330 * 2^F, doubled and offset for rounding
	assign cval     = adj_q[cmd.row][cmd.col];
	assign cmag     = cval[ADJ_W-1] ? ADJ_MAG_W'(-cval) : ADJ_MAG_W'(cval);
	assign cscaled  = (ADJ_MAG_W+SCALE_W)'(cmag) * (ADJ_MAG_W+SCALE_W)'(CAL_SCALE);
	assign dmag     = det_q[DET_W-1] ? DEN_W'(-det_q) : DEN_W'(det_q);
	assign dividend = (DVD_W'(cscaled) << (INV_FRAC_BITS + 1)) + DVD_W'(dmag);
	assign divisor  = {dmag, 1'b0};

	mcac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		if (neg_q)
			inv_val = (quo > Q_NEG_LIM) ? INV_W'(Q_NEG_LIM) : INV_W'(-quo);
		else
			inv_val = (quo > Q_POS_LIM) ? INV_W'(Q_POS_LIM) : INV_W'(quo);
	end

	assign raw_sel = raw_q[cmd.row];
	always_comb begin
		for (int i = 0; i < 3; i++)
			prod[i] = raw_sel * inv_q[cmd.row][i];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			dr_q     <= data_ready;
			raw_q[0] <= raw_x;
			raw_q[1] <= raw_y;
			raw_q[2] <= raw_z;
		end
		if (cmd.adj_en)
			adj_q[cmd.row][cmd.col] <= cof;
		if (cmd.det_clr)
			det_q <= '0;
		else if (cmd.det_en)
			det_q <= det_q + DET_W'(pd);
		if (cmd.div_start)
			neg_q <= cval[ADJ_W-1] ^ det_q[DET_W-1];
		for (int i = 0; i < 3; i++) begin
			if (cmd.mac_clr)
				acc_q[i] <= '0;
			else if (cmd.mac_en)
				acc_q[i] <= acc_q[i] + ACC_W'(prod[i]);
		end
		if (cmd.out_load) begin
			status_q <= cmd.status;
			if (!op_q) begin
				fx_q <= '0;
				fy_q <= '0;
				fz_q <= '0;
			end else begin
				fx_q <= out_axis(cfg.src[0], cfg.sign[0], lc_q[0], lc_q[1], lc_q[2]);
				fy_q <= out_axis(cfg.src[1], cfg.sign[1], lc_q[0], lc_q[1], lc_q[2]);
				fz_q <= out_axis(cfg.src[2], cfg.sign[2], lc_q[0], lc_q[1], lc_q[2]);
			end
		end
	end

	// Held inverse and last corrected sample reset to identity and zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				lc_q[r] <= '0;
				for (int c = 0; c < 3; c++)
					inv_q[r][c] <= (r == c) ? INV_ONE : '0;
			end
		end else begin
			if (cmd.ident_load) begin
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						inv_q[r][c] <= (r == c) ? INV_ONE : '0;
			end else if (cmd.inv_wr) begin
				inv_q[cmd.row][cmd.col] <= inv_val;
			end
			if (cmd.rnd_en)
				for (int i = 0; i < 3; i++)
					lc_q[i] <= acc_to_lc(acc_q[i]);
		end
	end

	assign sts.op         = op_q;
	assign sts.data_ready = dr_q;
	assign sts.no_factory = (w[0] == NO_FACTORY);
	assign sts.det_zero   = (det_q == '0);
	assign sts.div_done   = div_done;

	assign field_x = fx_q;
	assign field_y = fy_q;
	assign field_z = fz_q;
	assign status  = status_q;
endmodule

// ===== design/mcac_ctrl.sv =====
// Controller state machine sequencing calibration and sample processing.
module mcac_ctrl
	import mcac_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_stall,
	output logic out_valid
);
	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_DEC      = 10'b0000000010,
		S_MAC      = 10'b0000000100,
		S_RND      = 10'b0000001000,
		S_ADJ      = 10'b0000010000,
		S_DET      = 10'b0000100000,
		S_CHK      = 10'b0001000000,
		S_DIV_GO   = 10'b0010000000,
		S_DIV_WAIT = 10'b0100000000,
		S_FIN      = 10'b1000000000
	} state_t;

	state_t      state_q, state_d;
	logic [1:0]  r_q, r_d, c_q, c_d;
	res_status_t stat_q, stat_d;
	logic        ov_q;

	always_comb begin
		cmd        = '0;
		cmd.row    = r_q;
		cmd.col    = c_q;
		cmd.status = stat_q;
		state_d    = state_q;
		r_d        = r_q;
		c_d        = c_q;
		stat_d     = stat_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				r_d = '0;
				c_d = '0;
				if (sts.op) begin
					if (sts.data_ready) begin
						cmd.mac_clr = 1'b1;
						state_d = S_MAC;
					end else begin
						stat_d = ST_STALE;
						state_d = S_FIN;
					end
				end else if (sts.no_factory) begin
					cmd.ident_load = 1'b1;
					stat_d = ST_IDENTITY;
					state_d = S_FIN;
				end else begin
					cmd.det_clr = 1'b1;
					state_d = S_ADJ;
				end
			end
			S_MAC: begin
				cmd.mac_en = 1'b1;
				if (r_q == AXIS_LAST) begin
					r_d = '0;
					state_d = S_RND;
				end else
					r_d = r_q + 2'd1;
			end
			S_RND: begin
				cmd.rnd_en = 1'b1;
				stat_d = ST_FRESH;
				state_d = S_FIN;
			end
			S_ADJ: begin
				cmd.adj_en = 1'b1;
				if (c_q == AXIS_LAST) begin
					c_d = '0;
					if (r_q == AXIS_LAST) begin
						r_d = '0;
						state_d = S_DET;
					end else
						r_d = r_q + 2'd1;
				end else
					c_d = c_q + 2'd1;
			end
			S_DET: begin
				cmd.det_en = 1'b1;
				if (r_q == AXIS_LAST) begin
					r_d = '0;
					state_d = S_CHK;
				end else
					r_d = r_q + 2'd1;
			end
			S_CHK: begin
				if (sts.det_zero) begin
					cmd.ident_load = 1'b1;
					stat_d = ST_IDENTITY;
					state_d = S_FIN;
				end else begin
					stat_d = ST_FACTORY;
					state_d = S_DIV_GO;
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.inv_wr = 1'b1;
					if (c_q == AXIS_LAST) begin
						c_d = '0;
						if (r_q == AXIS_LAST) begin
							r_d = '0;
							state_d = S_FIN;
						end else begin
							r_d = r_q + 2'd1;
							state_d = S_DIV_GO;
						end
					end else begin
						c_d = c_q + 2'd1;
						state_d = S_DIV_GO;
					end
				end
			end
			S_FIN: begin
				if (!ov_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			stat_q  <= ST_FRESH;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			c_q     <= c_d;
			stat_q  <= stat_d;
			if (cmd.out_load)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ov_q;
endmodule

// ===== design/mag_cross_axis_correction.sv =====
// Flow: a fresh sample is captured, decoded, passed through the row MAC and rounding, then
// loaded into the output register; a stale sample goes from decode straight to output.
// Calibration: adjugate and determinant, then one restoring division per inverse entry,
// each producing one quotient bit per cycle. Throughput: one item in flight; the next
// is taken the cycle after the result is registered.
// Reset: arst_n clears control, loads the identity inverse and zero corrected sample.
module mag_cross_axis_correction
	import mcac_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic                        data_ready,
	input  logic signed [RAW_W-1:0]     raw_x,
	input  logic signed [RAW_W-1:0]     raw_y,
	input  logic signed [RAW_W-1:0]     raw_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OUT_W-1:0]     field_x,
	output logic signed [OUT_W-1:0]     field_y,
	output logic signed [OUT_W-1:0]     field_z,
	output logic [1:0]                  status,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [ROW_W-1:0]            cfg_data
);
	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// Configuration writes always land; the user must write only while the block is idle, which it does not enforce.
	assign cfg_ready = 1'b1;

	// Hold each register until its index is written; drop unknown indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows <= '0;
			cfg_q.src  <= {2'd2, 2'd1, 2'd0};
			cfg_q.sign <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROW_X: cfg_q.rows[0] <= cfg_data;
				CFG_ROW_Y: cfg_q.rows[1] <= cfg_data;
				CFG_ROW_Z: cfg_q.rows[2] <= cfg_data;
				CFG_SRC_X: cfg_q.src[0]  <= cfg_data[1:0];
				CFG_SRC_Y: cfg_q.src[1]  <= cfg_data[1:0];
				CFG_SRC_Z: cfg_q.src[2]  <= cfg_data[1:0];
				CFG_SIGN:  cfg_q.sign    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Controller: sequence the row MAC for samples and the adjugate,
	// determinant and division passes for calibration.
	mcac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// Datapath: hold the inverse and last corrected sample, register the result.
	mcac_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.op         (op),
		.data_ready (data_ready),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.raw_z      (raw_z),
		.sts        (sts),
		.field_x    (field_x),
		.field_y    (field_y),
		.field_z    (field_z),
		.status     (status)
	);
endmodule

// ===== design/mcac_checker.sv =====
// Port-level checker for the cross-axis correction block and its bind.
`include "assert_macros.svh"
module mcac_checker
	import mcac_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] field_x,
	input logic signed [OUT_W-1:0] field_y,
	input logic signed [OUT_W-1:0] field_z,
	input logic [1:0]              status
);
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(field_x) && $stable(field_y) && $stable(field_z) && $stable(status), "stalled transaction changed")
	`CHK_SAME(a_cal_zero, clk, arst_n, out_valid && (status == ST_FACTORY || status == ST_IDENTITY), field_x == '0 && field_y == '0 && field_z == '0, "calibration result not zero")
	`CHK_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall, "second transaction taken while busy")
	`CHK_NEXT(a_min_lat, clk, arst_n, in_valid && !in_stall, !$rose(out_valid), "result appeared too early")
endmodule

bind mag_cross_axis_correction mcac_checker u_mcac_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the magnetometer cross-axis correction block.
module tb_top;
	import mcac_pkg::*;

	localparam int LIMIT = 2000000;
	localparam int HOLD_OFF = 400;
	localparam int RANDOM_ITEMS = 630;
	localparam int PHASES = 10;

	typedef struct {
		longint fx;
		longint fy;
		longint fz;
		res_status_t st;
	} field_result_t;

	// Scoreboard: a private copy of the block's registers and state, the queue of
	// fields still owed by the block, and the mismatch count.
	class mag_scoreboard;
		logic [ROW_W-1:0] rows[3];
		logic [1:0] src[3];
		logic [2:0] neg_mask;
		longint inv[3][3];
		longint held[3];
		field_result_t owed[$];
		int errors;
		int n_in;

		function new();
			for (int i = 0; i < 3; i++) begin
				rows[i] = '0;
				src[i] = 2'(i);
				held[i] = 0;
			end
			neg_mask = '0;
			errors = 0;
			n_in = 0;
			load_identity();
		endfunction

		function void load_identity();
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					inv[i][j] = (i == j) ? (longint'(1) << INV_FRAC_BITS) : 0;
		endfunction

		function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] d);
			case (idx)
				CFG_ROW_X: rows[0] = d;
				CFG_ROW_Y: rows[1] = d;
				CFG_ROW_Z: rows[2] = d;
				CFG_SRC_X: src[0] = d[1:0];
				CFG_SRC_Y: src[1] = d[1:0];
				CFG_SRC_Z: src[2] = d[1:0];
				CFG_SIGN: neg_mask = d[2:0];
				default: ;
			endcase
		endfunction

		// Shift right by s, rounding half away from zero.
		function longint round_off(longint v, int s);
			longint m;
			m = (v < 0) ? -v : v;
			if (s > 0)
				m = (m + (longint'(1) << (s - 1))) >>> s;
			return (v < 0) ? -m : m;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// 330 * c * 2^F / d, rounded half away from zero, clamped to 24 bits.
		function longint inv_entry(longint c, longint d);
			longint unsigned num, den, q;
			num = longint'(c < 0 ? -c : c) * 330 * (longint'(1) << INV_FRAC_BITS);
			den = longint'(d < 0 ? -d : d);
			q = (2 * num + den) / (2 * den);
			if ((c < 0) != (d < 0))
				return (q > 64'd8388608) ? -8388608 : -longint'(q);
			return (q > 64'd8388607) ? 8388607 : longint'(q);
		endfunction

		function res_status_t calibrate();
			longint w[3][3];
			longint adj[3][3];
			longint det;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					w[i][j] = longint'($signed(rows[i][16*j +: 16]));
			if (w[0][0] == -1) begin
				load_identity();
				return ST_IDENTITY;
			end
			adj[0][0] = w[1][1] * w[2][2] - w[1][2] * w[2][1];
			adj[0][1] = w[0][2] * w[2][1] - w[0][1] * w[2][2];
			adj[0][2] = w[0][1] * w[1][2] - w[0][2] * w[1][1];
			adj[1][0] = w[1][2] * w[2][0] - w[1][0] * w[2][2];
			adj[1][1] = w[0][0] * w[2][2] - w[0][2] * w[2][0];
			adj[1][2] = w[0][2] * w[1][0] - w[0][0] * w[1][2];
			adj[2][0] = w[1][0] * w[2][1] - w[1][1] * w[2][0];
			adj[2][1] = w[0][1] * w[2][0] - w[0][0] * w[2][1];
			adj[2][2] = w[0][0] * w[1][1] - w[0][1] * w[1][0];
			det = w[0][0] * adj[0][0] + w[0][1] * adj[1][0] + w[0][2] * adj[2][0];
			if (det == 0) begin
				load_identity();
				return ST_IDENTITY;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					inv[i][j] = inv_entry(adj[i][j], det);
			return ST_FACTORY;
		endfunction

		function longint axis_out(int k);
			longint v;
			v = (src[k] < 3) ? held[src[k]] : 0;
			v = round_off(3 * v, 8);
			if (neg_mask[k])
				v = -v;
			return clamp(v, -8388608, 8388607);
		endfunction

		function void note_input(logic op_i, logic dr, logic signed [RAW_W-1:0] rx,
				logic signed [RAW_W-1:0] ry, logic signed [RAW_W-1:0] rz);
			field_result_t r;
			longint raw[3];
			longint acc;
			n_in++;
			if (!op_i) begin
				r.st = calibrate();
				r.fx = 0;
				r.fy = 0;
				r.fz = 0;
			end else begin
				if (dr) begin
					raw[0] = rx;
					raw[1] = ry;
					raw[2] = rz;
					for (int i = 0; i < 3; i++) begin
						acc = 0;
						for (int j = 0; j < 3; j++)
							acc += raw[j] * inv[j][i];
						held[i] = clamp(round_off(acc, INV_FRAC_BITS - 8),
							-64'sd2147483648, 64'sd2147483647);
					end
					r.st = ST_FRESH;
				end else begin
					r.st = ST_STALE;
				end
				r.fx = axis_out(0);
				r.fy = axis_out(1);
				r.fz = axis_out(2);
			end
			owed.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("MISMATCH %s: got %0d, want %0d", what, got, want);
		endtask

		task check_result(longint fx, longint fy, longint fz, logic [1:0] st);
			field_result_t r;
			if (owed.size() == 0) begin
				report("unexpected result, status", st, -1);
				return;
			end
			r = owed.pop_front();
			if (fx != r.fx) report("field_x", fx, r.fx);
			if (fy != r.fy) report("field_y", fy, r.fy);
			if (fz != r.fz) report("field_z", fz, r.fz);
			if (st != r.st) report("status", st, r.st);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b1;
	logic data_ready = 1'b0;
	logic signed [RAW_W-1:0] raw_x = '0;
	logic signed [RAW_W-1:0] raw_y = '0;
	logic signed [RAW_W-1:0] raw_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] field_x;
	logic signed [OUT_W-1:0] field_y;
	logic signed [OUT_W-1:0] field_z;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ROW_W-1:0] cfg_data = '0;

	mag_scoreboard sb = new();
	int cyc = 0;
	int burst_left = 0;
	bit hold_done = 1'b0;

	mag_cross_axis_correction DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .data_ready(data_ready),
		.raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.field_x(field_x), .field_y(field_y), .field_z(field_z), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("TIMEOUT after %0d cycles", cyc);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Monitors sample the pre-edge values, so they see exactly what the block sees.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.apply_cfg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_input(op, data_ready, raw_x, raw_y, raw_z);
			if (out_valid && !out_stall)
				sb.check_result(field_x, field_y, field_z, status);
		end
	end

	// Receiver: switch between random stall patterns, and once hold off
	// for a long stretch mid-run so the block backs up and stalls its input.
	initial begin
		int mode;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sb.n_in >= 250) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (cyc % 64 == 0)
					mode = $urandom_range(0, 2);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Offer one transaction and hold it until accepted. Valid stays high afterwards;
	// the task lowers it only when it inserts a gap.
	task automatic send_item(logic op_i, logic dr, logic [15:0] rx, logic [15:0] ry,
			logic [15:0] rz);
		int gap;
		in_valid <= 1'b1;
		op <= op_i;
		data_ready <= dr;
		raw_x <= rx;
		raw_y <= ry;
		raw_z <= rz;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait until every owed result is in, plus a margin for the pipe.
	// Wait for a clock edge first so the monitor has noted the last accepted transaction.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Write every register, plus the unused index, in one back-to-back run.
	task automatic write_regs(logic [ROW_W-1:0] vals[8]);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Build one factory row; style selects how well-conditioned the matrix is.
	function automatic logic [ROW_W-1:0] make_row(int r, int style);
		logic [15:0] w[3];
		for (int j = 0; j < 3; j++) begin
			case (style)
				0: w[j] = (j == r) ? 16'(330 + $urandom_range(0, 80) - 40)
					: 16'($urandom_range(0, 40) - 20);
				1: w[j] = 16'($urandom);
				default: w[j] = (j == r) ? 16'h7FFF : 16'h8000;
			endcase
		end
		return {w[2], w[1], w[0]};
	endfunction

	initial begin
		logic [ROW_W-1:0] regs[8];
		int style;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, stale before any fresh sample, field extremes,
		// a calibration on the all-zero rows (singular, so identity).
		send_item(1'b1, 1'b0, 16'h1234, 16'h5678, 16'h9ABC);
		send_item(1'b1, 1'b1, 16'h7FFF, 16'h8000, 16'h0000);
		send_item(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		send_item(1'b1, 1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);
		send_item(1'b1, 1'b1, 16'hFFFF, 16'h0001, 16'h8000);
		send_item(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(1'b1, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_item(1'b1, 1'b1, 16'h8000, 16'h8000, 16'h8000);
		send_item(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			// Cycle through conditioned, random and extreme matrices, a missing
			// factory word, a singular matrix, and selector and sign extremes.
			style = (ph % 5 == 1) ? 1 : ((ph % 5 == 2) ? 2 : 0);
			for (int r = 0; r < 3; r++)
				regs[r] = make_row(r, style);
			if (ph % 5 == 3)
				regs[0][15:0] = 16'hFFFF;
			if (ph % 5 == 4)
				regs[2] = regs[1];
			for (int k = 0; k < 3; k++)
				regs[3 + k] = (ph == 0) ? ROW_W'(k) : ((ph == 1) ? ROW_W'(3)
					: ROW_W'($urandom_range(0, 3)));
			regs[6] = (ph == 0) ? '0 : ((ph == 1) ? ROW_W'(7) : ROW_W'($urandom_range(0, 7)));
			regs[7] = ROW_W'({$urandom, $urandom});
			write_regs(regs);

			send_item(1'b0, 1'($urandom), pick_raw(), pick_raw(), pick_raw());
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
				send_item(($urandom_range(0, 19) != 0), ($urandom_range(0, 3) != 0),
					pick_raw(), pick_raw(), pick_raw());
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
